@@ sv/umra_pkg.sv @@
// umra_pkg: widths, codes and constants for the ultrasonic median range avoider.
// No dependencies; imported by the top level and its checker.

package umra_pkg;

	localparam int ECHO_W = 16;
	localparam int THR_W  = 9;
	localparam int DIST_W = 11;
	localparam int ACT_W  = 2;
	localparam int CFG_W  = 16;
	localparam int IDX_CFG_W = 1;

	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 16;
	localparam int M_PAD_W   = M_TDATA_W - DIST_W - ACT_W;

	// floor(w*17/1000) == (w * ceil(17*2^30/1000)) >> 30 for every 16-bit w
	localparam int CM_MULT_W = 25;
	localparam logic [CM_MULT_W-1:0] CM_MULT = 25'd18253612;
	localparam int CM_SHIFT = 30;
	localparam int PROD_W = ECHO_W + CM_MULT_W;

	localparam logic [ECHO_W-1:0] ECHO_LIMIT_RST = 16'd25000;
	localparam logic [THR_W-1:0]  OBST_THR_RST   = 9'd35;

	localparam logic [IDX_CFG_W-1:0] REG_ECHO_LIMIT = 1'd0;
	localparam logic [IDX_CFG_W-1:0] REG_OBST_THR   = 1'd1;

	localparam logic [ACT_W-1:0] ACT_NONE = 2'd0;
	localparam logic [ACT_W-1:0] ACT_TURN = 2'd1;
	localparam logic [ACT_W-1:0] ACT_STOP = 2'd2;

endpackage

@@ sv/ultrasonic_median_range_avoider.sv @@
// Ultrasonic median range avoider: echo width to cm, median per group, avoid action.
// Depends on umra_pkg.
//
//  channel | dir | payload                                    | handshake
//  s_*     | in  | tdata[15:0] echo_width                     | s_tvalid / s_tready
//  m_*     | out | tdata[10:0] median, [12:11] action         | m_tvalid / m_tready
//  cfg_*   | in  | cfg_idx 0 echo_limit, 1 obstacle_threshold | cfg_we, no wait
//
// One echo width per cycle sustained; the result of a group reaches the output
// register once its last input has passed the width register, then the median stage.
// The median is a rank count over the stored window, all in the median stage.
// If a result waits on m_tready while the next group is full, input stalls until
// the output register frees up. Reset clears control state; the window is not cleared.

module ultrasonic_median_range_avoider
	import umra_pkg::*;
#(
	parameter int WINDOW_SIZE = 5
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // [15:0] echo_width
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // [10:0] median_distance, [12:11] avoid_action, pad
	input  logic                 cfg_we,
	input  logic [IDX_CFG_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int IDX_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
	localparam int MED_RANK = WINDOW_SIZE / 2;

	logic [ECHO_W-1:0] echo_limit_q;
	logic [THR_W-1:0]  obst_thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			echo_limit_q <= ECHO_LIMIT_RST;
			obst_thr_q   <= OBST_THR_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_ECHO_LIMIT: echo_limit_q <= cfg_data[ECHO_W-1:0];
				REG_OBST_THR:   obst_thr_q   <= cfg_data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	// stage 1: captured echo width
	logic              vld_s1;
	logic [ECHO_W-1:0] width_s1;
	logic              grp_full_s2;
	logic              out_vld_q;
	logic              out_stall;
	logic              s2_hold;
	logic              s1_go;

	assign out_stall = out_vld_q && !m_tready;
	// a full window waiting on the output must not be overwritten
	assign s2_hold   = grp_full_s2 && out_stall;
	assign s1_go     = vld_s1 && !s2_hold;
	assign s_tready  = !vld_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			width_s1 <= s_tdata[ECHO_W-1:0];
		end
	end

	logic [PROD_W-1:0] prod;
	logic [DIST_W-1:0] dist_cm;

	assign prod = PROD_W'(width_s1) * PROD_W'(CM_MULT);
	assign dist_cm = (width_s1 < echo_limit_q) ? prod[CM_SHIFT+DIST_W-1:CM_SHIFT] : '0;

	logic [DIST_W-1:0] dist_mem [WINDOW_SIZE];
	logic [IDX_W-1:0]  cnt_q;
	logic              last_smp;

	assign last_smp = (cnt_q == IDX_W'(WINDOW_SIZE - 1));

	always_ff @(posedge clk) begin
		if (s1_go) begin
			dist_mem[cnt_q] <= dist_cm;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			grp_full_s2 <= 1'b0;
		end else begin
			if (s1_go) begin
				cnt_q <= last_smp ? '0 : cnt_q + IDX_W'(1);
			end
			if (s1_go && last_smp) begin
				grp_full_s2 <= 1'b1;
			end else if (!s2_hold) begin
				grp_full_s2 <= 1'b0;
			end
		end
	end

	// median stage: rank of each entry, ties broken by position
	logic [IDX_W-1:0]  rank [WINDOW_SIZE];
	logic [DIST_W-1:0] median;

	always_comb begin
		median = '0;
		for (int i = 0; i < WINDOW_SIZE; i++) begin
			rank[i] = '0;
			for (int j = 0; j < WINDOW_SIZE; j++) begin
				if (j != i) begin
					if ((dist_mem[j] < dist_mem[i]) || ((dist_mem[j] == dist_mem[i]) && (j < i))) begin
						rank[i] = rank[i] + IDX_W'(1);
					end
				end
			end
			if (rank[i] == IDX_W'(MED_RANK)) begin
				median = median | dist_mem[i];
			end
		end
	end

	logic             armed_q;
	logic             adv2;
	logic             near;
	logic [ACT_W-1:0] act;
	logic [DIST_W-1:0] med_q;
	logic [ACT_W-1:0]  act_q;

	assign adv2 = grp_full_s2 && !out_stall;
	assign near = median < DIST_W'(obst_thr_q);

	always_comb begin
		if (armed_q && near) begin
			act = ACT_TURN;
		end else if (!armed_q) begin
			act = ACT_STOP;
		end else begin
			act = ACT_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			armed_q   <= 1'b1;
		end else begin
			if (!out_stall) begin
				out_vld_q <= grp_full_s2;
			end
			if (adv2) begin
				if (armed_q && near) begin
					armed_q <= 1'b0;
				end else if (!armed_q) begin
					armed_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			med_q <= median;
			act_q <= act;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {{M_PAD_W{1'b0}}, act_q, med_q};

endmodule

@@ sv/umra_checker.sv @@
// umra_checker: port-level checks on the result stream of the avoider.
// Depends on umra_pkg; bound to ultrasonic_median_range_avoider below.

module umra_checker
	import umra_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata
);

	logic             xfer;
	logic [ACT_W-1:0] act;
	logic [ACT_W-1:0] last_act_q;

	assign xfer = m_tvalid && m_tready;
	assign act  = m_tdata[DIST_W+ACT_W-1:DIST_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_act_q <= ACT_NONE;
		end else if (xfer) begin
			last_act_q <= act;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (act != 2'd3) && (m_tdata[M_TDATA_W-1:DIST_W+ACT_W] == '0))
		else $error("bad action code or padding");

	// a turn disarms, so the next transfer must be a stop
	a_after_turn: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && (last_act_q == ACT_TURN) |-> act == ACT_STOP)
		else $error("turn not followed by stop");

	a_stop_src: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && (act == ACT_STOP) |-> last_act_q == ACT_TURN)
		else $error("stop while armed");

endmodule

bind ultrasonic_median_range_avoider umra_checker u_umra_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
